// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a rising clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/mcqa_pkg.sv -----
// types, constants and step decoding for the quadrature accumulator
`default_nettype none

package mcqa_pkg;

    localparam int CHANNELS  = 3;
    localparam int PHASE_W   = 6;
    localparam int KIND_W    = 1;
    localparam int CHAN_W    = 2;
    localparam int POS_W     = 8;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    typedef logic [1:0]              phase_t;
    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [CHAN_W-1:0]       chan_t;
    typedef logic [1:0]              dir_t;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam dir_t DIR_HOLD = 2'd0;
    localparam dir_t DIR_FWD  = 2'd1;
    localparam dir_t DIR_BWD  = 2'd2;

    localparam pos_t POS_MAX  = 8'sd126;
    localparam pos_t POS_MIN  = -8'sd126;
    localparam pos_t POS_ONE  = 8'sd1;
    localparam pos_t POS_ZERO = 8'sd0;

    localparam chan_t CHAN_FIRST = '0;
    localparam chan_t CHAN_LAST  = CHAN_W'(CHANNELS - 1);
    localparam chan_t CHAN_ONE   = CHAN_W'(1);

    // x4 decode of {new pair, old pair}
    function automatic dir_t step_dir(input phase_t now, input phase_t old);
        logic [3:0] code;
        begin
            code = {now, old};
            case (code)
                4'b0001, 4'b0111, 4'b1110, 4'b1000: step_dir = DIR_FWD;
                4'b0100, 4'b0010, 4'b1011, 4'b1101: step_dir = DIR_BWD;
                default:                            step_dir = DIR_HOLD;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/multi_channel_quadrature_accumulator.sv -----
// top level: three-channel x4 quadrature decoder with report-and-clear readout
//
//  side    | tdata              | tuser         | tlast
//  --------+--------------------+---------------+---------------------
//  s_axis  | phases [5:0]       | kind [0]      | -
//  m_axis  | position [7:0]     | channel [1:0] | last channel of run
//
// a sample transfer is taken every cycle while no report waits in the input register;
// it is registered there, and in the next cycle it updates all channel positions and phase pairs at once
// a report transfer snapshots and clears all positions, then drives one
// result transfer per channel, one per cycle while m_axis_tready is high, from a single output register;
// the next report can snapshot in the cycle the last channel moves into that register
// a report waits in the input register while the previous one still drains;
// samples keep flowing during the drain until a report waits in the input register
// rst_n clears positions, phase pairs and all valid flags asynchronously
`default_nettype none

`include "assert_macros.svh"

module multi_channel_quadrature_accumulator
(
    input  wire                             clk,
    input  wire                             rst_n,

    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // phases [5:0], zero pad [7:6]
    input  wire  [mcqa_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // kind [0]
    input  wire  [mcqa_pkg::KIND_W-1:0]     s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // position [7:0]
    output logic [mcqa_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // channel [1:0]
    output logic [mcqa_pkg::CHAN_W-1:0]     m_axis_tuser,
    output logic                            m_axis_tlast
);

    import mcqa_pkg::*;

    // input register
    logic               in_valid_reg, in_valid_next;
    logic               in_kind_reg;
    logic [PHASE_W-1:0] in_phases_reg;

    // per-channel state
    phase_t prev_reg [CHANNELS];
    phase_t prev_next [CHANNELS];
    pos_t   pos_reg [CHANNELS];
    pos_t   pos_next [CHANNELS];
    dir_t   dir [CHANNELS];

    // report snapshot and readout counter
    pos_t   snap_reg [CHANNELS];
    logic   rpt_busy_reg, rpt_busy_next;
    chan_t  rpt_idx_reg, rpt_idx_next;

    // output register
    logic   m_valid_reg, m_valid_next;
    pos_t   m_pos_reg;
    chan_t  m_chan_reg;
    logic   m_last_reg;

    logic   s_fire;
    logic   sample_fire;
    logic   snap_fire;
    logic   load_out;
    logic   buf_free;
    logic   in_advance;

    // readout: while a report drains, fill the output register whenever it is empty or being taken
    assign load_out   = rpt_busy_reg && (!m_valid_reg || m_axis_tready);
    // snapshot buffer frees up the cycle its last channel moves out
    assign buf_free   = !rpt_busy_reg || (load_out && (rpt_idx_reg == CHAN_LAST));

    assign sample_fire = in_valid_reg && (in_kind_reg == KIND_SAMPLE);
    assign snap_fire   = in_valid_reg && (in_kind_reg == KIND_REPORT) && buf_free;
    assign in_advance  = sample_fire || snap_fire;

    assign s_axis_tready = !in_valid_reg || in_advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (in_advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++)
        begin : g_dir
            assign dir[g] = step_dir(in_phases_reg[2*g +: 2], prev_reg[g]);
        end
    endgenerate

    // position and phase update, independent per channel
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            prev_next[i] = prev_reg[i];
            pos_next[i]  = pos_reg[i];
            if (snap_fire)
            begin
                pos_next[i] = POS_ZERO;
            end
            else if (sample_fire)
            begin
                prev_next[i] = in_phases_reg[2*i +: 2];
                case (dir[i])
                    DIR_FWD:
                    begin
                        if (pos_reg[i] != POS_MAX)
                        begin
                            pos_next[i] = pos_reg[i] + POS_ONE;
                        end
                    end
                    DIR_BWD:
                    begin
                        if (pos_reg[i] != POS_MIN)
                        begin
                            pos_next[i] = pos_reg[i] - POS_ONE;
                        end
                    end
                    default:
                    begin
                        pos_next[i] = pos_reg[i];
                    end
                endcase
            end
        end
    end

    // readout sequencing
    always_comb
    begin
        rpt_busy_next = rpt_busy_reg;
        rpt_idx_next  = rpt_idx_reg;
        m_valid_next  = m_valid_reg;
        if (load_out)
        begin
            m_valid_next = 1'b1;
            rpt_idx_next = rpt_idx_reg + CHAN_ONE;
            if (rpt_idx_reg == CHAN_LAST)
            begin
                rpt_busy_next = 1'b0;
            end
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (snap_fire)
        begin
            rpt_busy_next = 1'b1;
            rpt_idx_next  = CHAN_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            rpt_busy_reg <= 1'b0;
            rpt_idx_reg  <= CHAN_FIRST;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                prev_reg[i] <= '0;
                pos_reg[i]  <= POS_ZERO;
            end
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            rpt_busy_reg <= rpt_busy_next;
            rpt_idx_reg  <= rpt_idx_next;
            m_valid_reg  <= m_valid_next;
            for (int i = 0; i < CHANNELS; i++)
            begin
                prev_reg[i] <= prev_next[i];
                pos_reg[i]  <= pos_next[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_kind_reg   <= s_axis_tuser[0];
            in_phases_reg <= s_axis_tdata[PHASE_W-1:0];
        end
        if (snap_fire)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                snap_reg[i] <= pos_reg[i];
            end
        end
        if (load_out)
        begin
            m_pos_reg  <= snap_reg[rpt_idx_reg];
            m_chan_reg <= rpt_idx_reg;
            m_last_reg <= (rpt_idx_reg == CHAN_LAST);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_pos_reg;
    assign m_axis_tuser  = m_chan_reg;
    assign m_axis_tlast  = m_last_reg;

    // checks

    generate
        for (g = 0; g < CHANNELS; g++)
        begin : g_chk
            `ASSERT_NEVER(a_pos_range, clk, rst_n, (pos_reg[g] > POS_MAX) || (pos_reg[g] < POS_MIN), "position left saturation range")
        end
    endgenerate

    `ASSERT_CLK(a_last_chan, clk, rst_n, (m_valid_reg && m_last_reg) |-> (m_chan_reg == CHAN_LAST), "tlast on a channel other than the last")

    `ASSERT_CLK(a_snap_start, clk, rst_n, snap_fire |=> (rpt_busy_reg && (rpt_idx_reg == CHAN_FIRST)), "report readout did not restart at channel zero")

    `ASSERT_NEVER(a_idx_range, clk, rst_n, rpt_busy_reg && (rpt_idx_reg > CHAN_LAST), "readout counter past last channel")

endmodule

`default_nettype wire
